>>> sv/krrf_pkg.sv
// krrf_pkg: widths, constants and shared types of the k-mer repeat read filter
// used by every module of the block but krrf_ram; depends on nothing

package krrf_pkg;

  localparam int K_MAX       = 10;
  localparam int CODE_W      = 2 * K_MAX;
  localparam int TABLE_DEPTH = 1 << CODE_W;
  localparam int CNT_W       = 2;
  localparam int KLEN_W      = 4;
  localparam int RUN_W       = $clog2(K_MAX + 1);
  localparam int KEFF_W      = (RUN_W > KLEN_W) ? RUN_W : KLEN_W;
  localparam int CHAR_W      = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = KLEN_W;
  localparam int OPQ_DEPTH   = 4;
  localparam int OUTQ_DEPTH  = 2;

  localparam logic [KLEN_W-1:0] KMER_LEN_RESET = KLEN_W'(10);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KMER_LEN = 1'b0,
    REG_PHASE    = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [KLEN_W-1:0] kmer_len;
    logic              phase;
  } cfg_t;

  typedef struct packed {
    logic [CODE_W-1:0] idx;
    logic              access;
    logic              phase;
    logic              last;
    logic              amb;
  } op_t;

  typedef struct packed {
    logic keep;
    logic amb;
  } res_t;

endpackage

>>> sv/kmer_repeat_read_filter.sv
// kmer_repeat_read_filter: top level with configuration registers, front, op queue and back
// depends on krrf_pkg, krrf_front, krrf_opq, krrf_back
//
//   channel   | handshake                 | payload
//   ----------+---------------------------+----------------------------------
//   input     | push / full               | base_char_i, read_end_i
//   result    | empty / pop               | keep_read_o, ambiguous_seen_o
//   config    | cfg_valid_i / cfg_ready_o | cfg_idx_i, cfg_data_i
//
// one item per cycle sustained while the table is not being cleared and no read end item meets
// a full result queue; the table read-modify-write runs in two back stages with the last write
// forwarded, so repeated k-mers do not slow it down; an item with read end gives its result
// once it has passed the op queue and the back stage; after reset full stays high while the table is cleared
// a stalled result holds the back stage only once the two-entry result queue fills

module kmer_repeat_read_filter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic [krrf_pkg::CHAR_W-1:0]       base_char_i,
  input  logic                              read_end_i,
  output logic                              empty,
  input  logic                              pop,
  output logic                              keep_read_o,
  output logic                              ambiguous_seen_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [krrf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [krrf_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  krrf_pkg::cfg_t cfg_q;
  krrf_pkg::op_t  fe_op, q_op;
  krrf_pkg::res_t res;
  logic           clearing, opq_full, opq_empty, op_push, op_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kmer_len <= krrf_pkg::KMER_LEN_RESET;
      cfg_q.phase    <= 1'b0;
    end else if (cfg_valid_i) begin
      case (krrf_pkg::cfg_reg_e'(cfg_idx_i))
        krrf_pkg::REG_KMER_LEN: cfg_q.kmer_len <= cfg_data_i;
        krrf_pkg::REG_PHASE:    cfg_q.phase    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  krrf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .base_char_i (base_char_i),
    .read_end_i  (read_end_i),
    .cfg_i       (cfg_q),
    .clearing_i  (clearing),
    .opq_full_i  (opq_full),
    .full_o      (full),
    .op_push_o   (op_push),
    .op_o        (fe_op)
  );

  krrf_opq u_opq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (op_push),
    .data_i  (fe_op),
    .full_o  (opq_full),
    .pop_i   (op_pop),
    .empty_o (opq_empty),
    .data_o  (q_op)
  );

  krrf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (~opq_empty),
    .op_i        (q_op),
    .op_pop_o    (op_pop),
    .clearing_o  (clearing),
    .res_empty_o (empty),
    .res_o       (res),
    .res_pop_i   (pop)
  );

  assign keep_read_o      = res.keep;
  assign ambiguous_seen_o = res.amb;

endmodule

>>> sv/krrf_ram.sv
// krrf_ram: generic single write port, single read port ram with registered read
// no package dependency

module krrf_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/krrf_front.sv
// krrf_front: decodes read characters, keeps the rolling k-mer code and run length
// and hands one table operation per item to the op queue; depends on krrf_pkg

module krrf_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic [krrf_pkg::CHAR_W-1:0]    base_char_i,
  input  logic                           read_end_i,
  input  krrf_pkg::cfg_t                 cfg_i,
  input  logic                           clearing_i,
  input  logic                           opq_full_i,
  output logic                           full_o,
  output logic                           op_push_o,
  output krrf_pkg::op_t                  op_o
);

  logic [krrf_pkg::CODE_W-1:0] code_q, code_d, code_shift, code_mask;
  logic [krrf_pkg::RUN_W-1:0]  run_q, run_d;
  logic                        amb_q, amb_now;
  logic [krrf_pkg::KEFF_W-1:0] k_eff, klen_ext;
  logic                        base_ok, access, accept;
  logic [1:0]                  base_code;

  always_comb begin
    base_ok   = 1'b1;
    base_code = 2'd0;
    case (base_char_i)
      "A", "a": base_code = 2'd0;
      "C", "c": base_code = 2'd1;
      "G", "g": base_code = 2'd2;
      "T", "t": base_code = 2'd3;
      default:  base_ok   = 1'b0;
    endcase
  end

  always_comb begin
    klen_ext = krrf_pkg::KEFF_W'(cfg_i.kmer_len);
    if (klen_ext == '0) begin
      k_eff = krrf_pkg::KEFF_W'(1);
    end else if (klen_ext > krrf_pkg::KEFF_W'(krrf_pkg::K_MAX)) begin
      k_eff = krrf_pkg::KEFF_W'(krrf_pkg::K_MAX);
    end else begin
      k_eff = klen_ext;
    end
  end

  always_comb begin
    for (int j = 0; j < krrf_pkg::K_MAX; j++) begin
      code_mask[2*j +: 2] = (krrf_pkg::KEFF_W'(j) < k_eff) ? 2'b11 : 2'b00;
    end
    code_shift = (code_q << 2) | krrf_pkg::CODE_W'(base_code);
  end

  always_comb begin
    if (!base_ok) begin
      code_d  = '0;
      run_d   = '0;
      amb_now = 1'b1;
      access  = 1'b0;
    end else begin
      code_d  = code_shift & code_mask;
      run_d   = (run_q < krrf_pkg::RUN_W'(krrf_pkg::K_MAX)) ? run_q + 1'b1 : run_q;
      amb_now = amb_q;
      access  = krrf_pkg::KEFF_W'(run_d) >= k_eff;
    end
  end

  assign full_o    = clearing_i | opq_full_i;
  assign accept    = push_i & ~full_o;
  assign op_push_o = accept;

  always_comb begin
    op_o.idx    = code_d;
    op_o.access = access;
    op_o.phase  = cfg_i.phase;
    op_o.last   = read_end_i;
    op_o.amb    = amb_now;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q <= '0;
      run_q  <= '0;
      amb_q  <= 1'b0;
    end else if (accept) begin
      if (read_end_i) begin
        code_q <= '0;
        run_q  <= '0;
        amb_q  <= 1'b0;
      end else begin
        code_q <= code_d;
        run_q  <= run_d;
        amb_q  <= amb_now;
      end
    end
  end

endmodule

>>> sv/krrf_opq.sv
// krrf_opq: short queue of table operations between the front and back parts
// depends on krrf_pkg

module krrf_opq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  krrf_pkg::op_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output krrf_pkg::op_t data_o
);

  localparam int PtrW = $clog2(krrf_pkg::OPQ_DEPTH);

  krrf_pkg::op_t   entry_q [krrf_pkg::OPQ_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;
  logic            do_push, do_pop;

  assign full_o  = count_q == (PtrW+1)'(krrf_pkg::OPQ_DEPTH);
  assign empty_o = count_q == '0;
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

>>> sv/krrf_back.sv
// krrf_back: clears the counter table after reset, runs the table read-modify-write
// with forwarding, gathers per-read verdicts and queues results; depends on krrf_pkg, krrf_ram

module krrf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          op_valid_i,
  input  krrf_pkg::op_t op_i,
  output logic          op_pop_o,
  output logic          clearing_o,
  output logic          res_empty_o,
  output krrf_pkg::res_t res_o,
  input  logic          res_pop_i
);

  localparam logic [krrf_pkg::CNT_W-1:0] CntZero = krrf_pkg::CNT_W'(0);
  localparam logic [krrf_pkg::CNT_W-1:0] CntOnce = krrf_pkg::CNT_W'(1);
  localparam logic [krrf_pkg::CNT_W-1:0] CntMany = krrf_pkg::CNT_W'(3);
  localparam int OutPtrW = $clog2(krrf_pkg::OUTQ_DEPTH);

  logic                         clearing_q;
  logic [krrf_pkg::CODE_W-1:0]  clr_addr_q;
  logic                         b_valid_q;
  krrf_pkg::op_t                b_op_q;
  logic                         rej_q, rej_now, hit_bad;
  logic                         fwd_valid_q;
  logic [krrf_pkg::CODE_W-1:0]  fwd_idx_q;
  logic [krrf_pkg::CNT_W-1:0]   fwd_cnt_q;
  logic [krrf_pkg::CNT_W-1:0]   rdata, cur_cnt, upd_cnt;
  logic                         a_go, b_go, wr_tbl;
  logic                         ram_we;
  logic [krrf_pkg::CODE_W-1:0]  ram_waddr;
  logic [krrf_pkg::CNT_W-1:0]   ram_wdata;
  krrf_pkg::res_t               res_new;
  krrf_pkg::res_t               outq_q [krrf_pkg::OUTQ_DEPTH];
  logic [OutPtrW-1:0]           out_wr_q, out_rd_q;
  logic [OutPtrW:0]             out_cnt_q;
  logic                         out_full, out_push, out_pop;

  assign out_full = out_cnt_q == (OutPtrW+1)'(krrf_pkg::OUTQ_DEPTH);
  assign b_go     = b_valid_q & (~b_op_q.last | ~out_full);
  assign a_go     = ~clearing_q & op_valid_i & (~b_valid_q | b_go);
  assign op_pop_o = a_go;

  // latest write wins over the registered ram read
  assign cur_cnt = (fwd_valid_q && fwd_idx_q == b_op_q.idx) ? fwd_cnt_q : rdata;
  assign upd_cnt = (cur_cnt == CntZero) ? CntOnce : CntMany;
  assign wr_tbl  = b_go & b_op_q.access & ~b_op_q.phase;
  assign hit_bad = b_op_q.access & b_op_q.phase & (cur_cnt != CntMany);
  assign rej_now = rej_q | hit_bad;

  always_comb begin
    res_new.keep = b_op_q.phase & ~rej_now & ~b_op_q.amb;
    res_new.amb  = b_op_q.amb;
  end

  assign ram_we    = clearing_q | wr_tbl;
  assign ram_waddr = clearing_q ? clr_addr_q : b_op_q.idx;
  assign ram_wdata = clearing_q ? CntZero : upd_cnt;

  krrf_ram #(
    .WIDTH (krrf_pkg::CNT_W),
    .DEPTH (krrf_pkg::TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (a_go),
    .raddr_i (op_i.idx),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (a_go) begin
      b_op_q <= op_i;
    end
    if (wr_tbl) begin
      fwd_idx_q <= b_op_q.idx;
      fwd_cnt_q <= upd_cnt;
    end
    if (out_push) begin
      outq_q[out_wr_q] <= res_new;
    end
  end

  assign out_push    = b_go & b_op_q.last;
  assign out_pop     = res_pop_i & (out_cnt_q != '0);
  assign res_empty_o = out_cnt_q == '0;
  assign res_o       = outq_q[out_rd_q];
  assign clearing_o  = clearing_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q  <= 1'b1;
      clr_addr_q  <= '0;
      b_valid_q   <= 1'b0;
      rej_q       <= 1'b0;
      fwd_valid_q <= 1'b0;
      out_wr_q    <= '0;
      out_rd_q    <= '0;
      out_cnt_q   <= '0;
    end else begin
      if (clearing_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (&clr_addr_q) begin
          clearing_q <= 1'b0;
        end
      end
      if (a_go) begin
        b_valid_q <= 1'b1;
      end else if (b_go) begin
        b_valid_q <= 1'b0;
      end
      if (b_go) begin
        rej_q <= b_op_q.last ? 1'b0 : rej_now;
      end
      if (wr_tbl) begin
        fwd_valid_q <= 1'b1;
      end
      if (out_push) begin
        out_wr_q <= out_wr_q + 1'b1;
      end
      if (out_pop) begin
        out_rd_q <= out_rd_q + 1'b1;
      end
      if (out_push && !out_pop) begin
        out_cnt_q <= out_cnt_q + 1'b1;
      end else if (out_pop && !out_push) begin
        out_cnt_q <= out_cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> sv/krrf_checker.sv
// krrf_checker: port-level checks on the k-mer repeat read filter, bound to the top level
// depends on krrf_pkg

module krrf_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        push,
  input logic                        full,
  input logic [krrf_pkg::CHAR_W-1:0] base_char_i,
  input logic                        read_end_i,
  input logic                        empty,
  input logic                        pop,
  input logic                        keep_read_o,
  input logic                        ambiguous_seen_o
);

  // reads ended at the input whose results are not yet taken
  logic [3:0] pend_q;
  logic       end_in, res_out;

  assign end_in  = push & ~full & read_end_i;
  assign res_out = pop & ~empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (end_in && !res_out) begin
      pend_q <= pend_q + 1'b1;
    end else if (res_out && !end_in) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  a_hold_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result withdrawn before pop");

  a_hold_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> ($stable(keep_read_o) && $stable(ambiguous_seen_o)))
    else $error("result changed while stalled");

  a_keep_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(keep_read_o && ambiguous_seen_o))
    else $error("read kept although ambiguous");

  a_no_invented : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (pend_q != '0))
    else $error("result without a finished read");

  a_ambig_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (end_in && base_char_i == 8'h00) |=> (pend_q != '0))
    else $error("read end item not counted");

endmodule

bind kmer_repeat_read_filter krrf_checker u_krrf_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .push             (push),
  .full             (full),
  .base_char_i      (base_char_i),
  .read_end_i       (read_end_i),
  .empty            (empty),
  .pop              (pop),
  .keep_read_o      (keep_read_o),
  .ambiguous_seen_o (ambiguous_seen_o)
);
